// File: rtl/trle_pkg.sv
// trle_pkg: shared types and constants of the run-length text expander
// depends on nothing; imported by the controller, the datapath, the top level, the checker and the bench

package trle_pkg;

    localparam int SymW   = 8;
    localparam int CountW = 7;

    localparam logic [SymW-1:0] DIGIT_LO     = 8'd48;
    localparam logic [SymW-1:0] DIGIT_HI     = 8'd57;
    localparam logic [SymW-1:0] RESET_SYMBOL = 8'd65;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXPAND
    } trle_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic fold_digit;
        logic emit_copy;
        logic emit_symbol;
        logic clear_word;
    } trle_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_digit;
        logic more_copies;
        logic eow_held;
        logic out_free;
    } trle_status_t;

endpackage

// File: rtl/trle_ctrl.sv
// trle_ctrl: controller state machine of the run-length text expander
// depends on trle_pkg; drives trle_dp through trle_cmd_t

module trle_ctrl
    import trle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  trle_status_t status,
    output trle_cmd_t    cmd
);

    trle_state_t state_reg;
    trle_state_t state_next;
    logic        accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tlast || !status.is_digit))
                begin
                    state_next = ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (!status.more_copies && (status.eow_held || status.out_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (!s_tlast && status.is_digit)
                    begin
                        cmd.fold_digit = 1'b1;
                    end
                    else
                    begin
                        cmd.load_in = 1'b1;
                    end
                end
            end
            ST_EXPAND:
            begin
                if (status.more_copies)
                begin
                    cmd.emit_copy = status.out_free;
                end
                else if (status.eow_held)
                begin
                    cmd.clear_word = 1'b1;
                end
                else
                begin
                    cmd.emit_symbol = status.out_free;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/trle_dp.sv
// trle_dp: datapath of the run-length text expander (count, held symbol, output register)
// depends on trle_pkg; commanded by trle_ctrl

module trle_dp
    import trle_pkg::*;
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [SymW-1:0] s_tdata,
    input  logic            s_tlast,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [SymW-1:0] m_tdata,
    output logic            m_tlast,
    input  trle_cmd_t       cmd,
    output trle_status_t    status
);

    localparam logic [9:0] MaxCountW = 10'(MAX_COUNT);

    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic [SymW-1:0]   held_reg;
    logic [SymW-1:0]   byte_reg;
    logic              eow_reg;
    logic              m_tvalid_reg;
    logic [SymW-1:0]   m_tdata_reg;
    logic              m_tlast_reg;
    logic [9:0]        count_wide;
    logic [9:0]        folded;

    // count*10 + digit, saturating
    assign count_wide = {3'b000, count_reg};
    assign folded     = (count_wide << 3) + (count_wide << 1) + {6'b000000, s_tdata[3:0]};
    assign count_next = (folded > MaxCountW) ? MaxCountW[CountW-1:0] : folded[CountW-1:0];

    always_comb
    begin
        status.is_digit    = s_tdata inside {[DIGIT_LO:DIGIT_HI]};
        status.more_copies = count_reg > 7'd1;
        status.eow_held    = eow_reg;
        status.out_free    = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            held_reg     <= RESET_SYMBOL;
            eow_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fold_digit)
            begin
                count_reg <= count_next;
            end
            else if (cmd.emit_copy)
            begin
                count_reg <= count_reg - 7'd1;
            end
            else if (cmd.emit_symbol || cmd.clear_word)
            begin
                count_reg <= '0;
            end

            if (cmd.emit_symbol)
            begin
                held_reg <= byte_reg;
            end
            else if (cmd.clear_word)
            begin
                held_reg <= RESET_SYMBOL;
            end

            if (cmd.load_in)
            begin
                eow_reg <= s_tlast;
            end

            if (cmd.emit_copy || cmd.emit_symbol)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            byte_reg <= s_tdata;
        end
        if (cmd.emit_copy)
        begin
            m_tdata_reg <= held_reg;
            m_tlast_reg <= eow_reg && (count_reg == 7'd2);
        end
        else if (cmd.emit_symbol)
        begin
            m_tdata_reg <= byte_reg;
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/text_run_length_expander_core.sv
// text_run_length_expander_core: top level of the run-length text expander
// depends on trle_pkg, trle_ctrl and trle_dp
//
//  channel  dir  handshake            tdata       tlast
//  s_*      in   s_tvalid/s_tready    symbol_in   end_of_word
//  m_*      out  m_tvalid/m_tready    symbol_out  last_of_run
//
//  a digit request is taken and s_tready stays high
//  a symbol request enters, then emits its copies and the symbol while s_tready is low
//  an end-of-word request enters, emits its copies, then clears the word
//  the single output register stalls the expansion while it holds a byte and m_tready is low
//  reset gives a count of zero and a held symbol of 'A'

module text_run_length_expander_core
    import trle_pkg::*;
#(
    parameter int MAX_COUNT = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [SymW-1:0] s_tdata,   // [7:0] symbol_in
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [SymW-1:0] m_tdata,   // [7:0] symbol_out
    output logic            m_tlast
);

    trle_cmd_t    cmd;
    trle_status_t status;

    trle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    trle_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// File: rtl/trle_checker.sv
// trle_checker: port-level checks of the run-length text expander
// depends on trle_pkg; bound to text_run_length_expander_core

module trle_checker
    import trle_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic [SymW-1:0] s_tdata,
    input logic            s_tlast,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [SymW-1:0] m_tdata,
    input logic            m_tlast
);

    logic s_digit;

    assign s_digit = (s_tdata >= DIGIT_LO) && (s_tdata <= DIGIT_HI);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // a digit never stops the input side
    a_digit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && s_digit |=> s_tready)
        else $error("input stalled after a digit");

    // a symbol or end of word blocks the input for its expansion
    a_expand_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tlast || !s_digit) |=> !s_tready)
        else $error("input taken during expansion");

    // an unfinished run keeps the input closed
    a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a run");

endmodule

bind text_run_length_expander_core trle_checker u_trle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: verif/tb_text_run_length_expander_core.sv
// tb_text_run_length_expander_core: self-checking bench for the run-length text expander
// depends on trle_pkg and text_run_length_expander_core; predicts every expanded byte
// from the accepted requests and compares each output byte as it leaves the block

module tb_text_run_length_expander_core;
    import trle_pkg::*;

    localparam int MaxRepeat   = 64;
    localparam int IdleLimit   = 4000;
    localparam int HoldCycles  = 300;
    localparam int RandomItems = 450;

    typedef struct {
        logic [SymW-1:0] sym;
        logic            last;
    } expanded_byte_t;

    class expansion_scoreboard;
        logic [CountW-1:0] repeat_count;
        logic [SymW-1:0]   held_sym;
        expanded_byte_t    pending_bytes[$];
        int                mismatches;

        function new();
            mismatches = 0;
            clear_word();
        endfunction

        function void clear_word();
            repeat_count = '0;
            held_sym     = RESET_SYMBOL;
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        function void push_byte(logic [SymW-1:0] sym, logic last);
            expanded_byte_t b;
            b.sym  = sym;
            b.last = last;
            pending_bytes.push_back(b);
        endfunction

        function void note_request(logic [SymW-1:0] sym, logic eow);
            int copies;
            int folded;
            copies = (repeat_count >= 2) ? int'(repeat_count) - 1 : 0;
            if (eow)
            begin
                for (int k = 0; k < copies; k++)
                    push_byte(held_sym, k == copies - 1);
                clear_word();
            end
            else if (sym >= DIGIT_LO && sym <= DIGIT_HI)
            begin
                folded = int'(repeat_count) * 10 + int'(sym - DIGIT_LO);
                if (folded > MaxRepeat)
                    folded = MaxRepeat;
                repeat_count = folded[CountW-1:0];
            end
            else
            begin
                for (int k = 0; k < copies; k++)
                    push_byte(held_sym, 1'b0);
                push_byte(sym, 1'b1);
                held_sym     = sym;
                repeat_count = '0;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [SymW-1:0] sym, logic last);
            expanded_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %0d last %0b", sym, last));
                return;
            end
            want = pending_bytes.pop_front();
            if (sym !== want.sym)
                report($sformatf("symbol_out got %0d want %0d", sym, want.sym));
            if (last !== want.last)
                report($sformatf("last_of_run got %0b want %0b", last, want.last));
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [SymW-1:0] s_tdata;
    logic            s_tlast;
    logic            m_tvalid;
    logic            m_tready;
    logic [SymW-1:0] m_tdata;
    logic            m_tlast;

    expansion_scoreboard sb;
    int burst_left;
    int items_sent;
    int idle_cycles;
    bit hold_off_request;

    text_run_length_expander_core #(
        .MAX_COUNT(MaxRepeat)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // request and result monitor, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    initial
    begin
        int mode;
        int phase;
        m_tready = 1'b0;
        mode     = 0;
        phase    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_off_request = 1'b0;
            end
            else
            begin
                if (phase == 0)
                begin
                    mode  = $urandom_range(0, 3);
                    phase = $urandom_range(20, 80);
                end
                phase--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= phase[0];
                endcase
            end
        end
    end

    task automatic send_request(input logic [SymW-1:0] sym, input logic eow);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= eow;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_count(input int count);
        int digits[$];
        int v;
        v = count;
        do
        begin
            digits.push_front(v % 10);
            v = v / 10;
        end
        while (v > 0);
        foreach (digits[i])
            send_request(DIGIT_LO + digits[i][SymW-1:0], 1'b0);
    endtask

    function automatic logic [SymW-1:0] random_symbol();
        logic [SymW-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= DIGIT_LO && b <= DIGIT_HI);
        return b;
    endfunction

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
        burst_left = $urandom_range(1, 12);
    endtask

    initial
    begin
        int pick;
        int n;
        sb               = new();
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tlast          = 1'b0;
        burst_left       = 0;
        items_sent       = 0;
        idle_cycles      = 0;
        hold_off_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // count before any symbol repeats the reset symbol
        send_count(3);
        send_request("x", 1'b0);
        // counts of zero and one leave one copy
        send_count(0);
        send_request("b", 1'b0);
        send_count(1);
        send_request("c", 1'b0);
        send_count(2);
        send_request("d", 1'b0);
        // saturating count gives the longest expansion
        send_count(99);
        send_request("e", 1'b0);
        // extremes and bytes next to the digit range
        send_request(8'h00, 1'b0);
        send_request(8'hff, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(DIGIT_LO - 8'd1, 1'b0);
        send_request(DIGIT_HI + 8'd1, 1'b0);
        // end of word with a pending count, then with nothing pending
        send_count(5);
        send_request(8'h00, 1'b1);
        send_request(8'hff, 1'b1);
        send_count(4);
        send_request("Z", 1'b0);
        send_count(2);
        send_request(DIGIT_LO + 8'd7, 1'b1);

        while (items_sent < RandomItems)
        begin
            if (items_sent >= 150 && items_sent < 160)
            begin
                // receiver holds off while requests keep coming
                hold_off_request = 1'b1;
                burst_left = 40;
                send_request("Q", 1'b0);
                send_count(64);
                send_request("R", 1'b0);
                send_count(9);
                send_request("S", 1'b0);
                send_request("T", 1'b0);
                send_count(30);
                send_request(8'h00, 1'b1);
                wait_for_drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_request(random_symbol(), 1'b0);
                pick = $urandom_range(0, 99);
                if (pick >= 40)
                begin
                    if (pick < 85)
                        n = $urandom_range(0, 12);
                    else if (pick < 95)
                        n = $urandom_range(13, 40);
                    else
                        n = $urandom_range(41, 120);
                    if ($urandom_range(0, 9) == 0)
                        send_request(DIGIT_LO, 1'b0);
                    send_count(n);
                    if ($urandom_range(0, 4) == 0)
                        send_request(8'($urandom_range(0, 255)), 1'b1);
                end
            end
            else
                send_request(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (MaxRepeat + 8) @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
